// File: rtl/wnr_pkg.sv
// Shared types and widths for the weighted neighbor regrid block.
// Used by the accumulator front end, the cell queue and the divider back end.
package wnr_pkg;

	localparam int VAL_W  = 32;  // Q16.16 sample and result
	localparam int WT_W   = 24;  // Q7.16 weight below an exact-match flag bit
	localparam int PROD_W = VAL_W + WT_W;
	localparam int SUM_W  = 64;  // numerator, Q32.32
	localparam int DEN_W  = 32;  // denominator, Q16.16

	// Finished cell summary handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] wsum;
		logic [DEN_W-1:0]        wtsum;
		logic [VAL_W-1:0]        exact_sample;
		logic                    exact_seen;
	} cell_t;

endpackage

// File: rtl/wnr_front.sv
// Front end: accepts neighbor items, multiplies, and accumulates per cell.
// On the last neighbor pushes a wnr_pkg::cell_t summary and clears its sums.
module wnr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [wnr_pkg::VAL_W-1:0]  sample_value,
	input  logic signed [wnr_pkg::WT_W-1:0]   weight,
	input  logic                              last_neighbor,
	output logic                              push,
	input  logic                              push_ready,
	output wnr_pkg::cell_t                    push_data
);

	localparam int SW = wnr_pkg::SUM_W;
	localparam int DW = wnr_pkg::DEN_W;

	logic                             valid_s1;
	logic signed [wnr_pkg::PROD_W-1:0] prod_s1;
	logic [wnr_pkg::WT_W-2:0]         wt_s1;
	logic                             exact_s1;
	logic                             last_s1;
	logic [wnr_pkg::VAL_W-1:0]        sample_s1;

	logic signed [SW-1:0]      wsum_q;
	logic [DW-1:0]             wtsum_q;
	logic [wnr_pkg::VAL_W-1:0] exs_q;
	logic                      exseen_q;

	logic           advance;
	logic           accept;
	logic [SW:0]    sum_ext;
	logic [DW:0]    wt_ext;
	wnr_pkg::cell_t nxt;

	assign advance  = valid_s1 && (!last_s1 || push_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	assign sum_ext = {wsum_q[SW-1], wsum_q} + (SW+1)'(prod_s1);
	assign wt_ext  = (DW+1)'(wtsum_q) + (DW+1)'(wt_s1);

	always_comb begin
		nxt.wsum         = wsum_q;
		nxt.wtsum        = wtsum_q;
		nxt.exact_sample = exs_q;
		nxt.exact_seen   = exseen_q;
		if (exact_s1) begin
			nxt.exact_sample = sample_s1;
			nxt.exact_seen   = 1'b1;
		end else begin
			// saturate at the signed 64-bit limits
			if (sum_ext[SW] != sum_ext[SW-1])
				nxt.wsum = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			else
				nxt.wsum = sum_ext[SW-1:0];
			nxt.wtsum = wt_ext[DW] ? {DW{1'b1}} : wt_ext[DW-1:0];
		end
	end

	assign push      = valid_s1 && last_s1 && push_ready;
	assign push_data = nxt;

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1   <= sample_value * weight;
			wt_s1     <= weight[wnr_pkg::WT_W-2:0];
			exact_s1  <= weight[wnr_pkg::WT_W-1];
			last_s1   <= last_neighbor;
			sample_s1 <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wsum_q   <= '0;
			wtsum_q  <= '0;
			exs_q    <= '0;
			exseen_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				if (last_s1) begin
					wsum_q   <= '0;
					wtsum_q  <= '0;
					exs_q    <= '0;
					exseen_q <= 1'b0;
				end else begin
					wsum_q   <= nxt.wsum;
					wtsum_q  <= nxt.wtsum;
					exs_q    <= nxt.exact_sample;
					exseen_q <= nxt.exact_seen;
				end
			end
		end
	end

endmodule

// File: rtl/wnr_queue.sv
// Small FIFO of finished cell summaries between front and back end.
// Array storage plus a registered head entry; uses wnr_pkg::cell_t.
module wnr_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  wnr_pkg::cell_t push_data,
	output logic           head_valid,
	input  logic           pop,
	output wnr_pkg::cell_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wnr_pkg::cell_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           head_valid_q;
	wnr_pkg::cell_t head_q;
	logic           load;
	logic           do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign do_pop     = pop && head_valid_q;
	assign load       = (cnt_q != '0) && (!head_valid_q || do_pop);
	assign head_valid = head_valid_q;
	assign head       = head_q;

	always_ff @(posedge clk) begin
		if (push && push_ready)
			mem[wr_ptr_q] <= push_data;
		if (load)
			head_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (push && push_ready)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (load)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CW'(push && push_ready) - CW'(load);
			if (load)
				head_valid_q <= 1'b1;
			else if (do_pop)
				head_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/wnr_back.sv
// Back end: resolves each cell summary to a result, dividing one quotient bit
// per cycle, and holds the missing-value register and the output register.
module wnr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wnr_pkg::VAL_W-1:0]        cfg_wdata,
	input  logic                             head_valid,
	output logic                             pop,
	input  wnr_pkg::cell_t                   head,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [wnr_pkg::VAL_W-1:0] result_value,
	output logic                             is_missing
);

	localparam int SW = wnr_pkg::SUM_W;
	localparam int DW = wnr_pkg::DEN_W;
	localparam int VW = wnr_pkg::VAL_W;
	localparam int CNT_W = $clog2(SW);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [VW-1:0]     miss_q;
	logic [SW-1:0]     quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [VW-1:0]     res_q;
	logic              miss_flag_q;

	logic [DW:0]   rem_sh;
	logic          qbit;
	logic [DW:0]   rem_dif;
	logic          rnd;
	logic [SW:0]   q_rnd;
	logic [VW-1:0] fin_val;

	assign pop = (state_q == S_IDLE) && head_valid && !out_valid_q;

	assign rem_sh  = {rem_q, quo_q[SW-1]};
	assign rem_dif = rem_sh - {1'b0, den_q};
	assign qbit    = rem_sh >= {1'b0, den_q};

	// round half away from zero on the magnitude, then saturate
	assign rnd   = {rem_q, 1'b0} >= {1'b0, den_q};
	assign q_rnd = {1'b0, quo_q} + (SW+1)'(rnd);

	always_comb begin
		if (!neg_q)
			fin_val = (q_rnd > (SW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_rnd[VW-1:0];
		else
			fin_val = (q_rnd > (SW+1)'(32'h8000_0000)) ? 32'h8000_0000
				: (32'd0 - q_rnd[VW-1:0]);
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q;
	assign is_missing   = miss_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			res_q       <= '0;
			miss_flag_q <= 1'b0;
		end else begin
			if (cfg_we)
				miss_q <= cfg_wdata;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.wtsum == '0) begin
							res_q       <= miss_q;
							miss_flag_q <= 1'b1;
							out_valid_q <= 1'b1;
						end else if (head.exact_seen) begin
							res_q       <= head.exact_sample;
							miss_flag_q <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							neg_q   <= head.wsum[SW-1];
							quo_q   <= head.wsum[SW-1] ? (SW'(0) - head.wsum) : head.wsum;
							rem_q   <= '0;
							den_q   <= head.wtsum;
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= {quo_q[SW-2:0], qbit};
					rem_q <= qbit ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SW - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					res_q       <= fin_val;
					miss_flag_q <= 1'b0;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/weighted_neighbor_regrid.sv
// Weighted neighbor regrid: top level joining the front end, cell queue and back end.
// Depends on wnr_pkg, wnr_front, wnr_queue and wnr_back.
//
// Neighbor items are taken one per cycle unless a finished cell waits for queue
// space; each is multiplied by its weight (a registered multiply) and the
// product is folded into saturating per-cell sums. A cell summary is queued
// on its last neighbor. The back end then resolves each cell: a zero weight
// sum gives the configured fill value with is_missing set, otherwise an exact
// match gives its sample, and a weighted average takes 64 restoring divide
// steps, one quotient bit per cycle, then a rounding and saturation step.
// The input keeps streaming while up to QUEUE_DEPTH finished cells wait for
// the divider, plus one in the queue head. The fill value is written through
// cfg_we/cfg_wdata and resets to zero.
module weighted_neighbor_regrid #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wnr_pkg::VAL_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [wnr_pkg::VAL_W-1:0] sample_value,
	input  logic signed [wnr_pkg::WT_W-1:0]  weight,
	input  logic                             last_neighbor,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [wnr_pkg::VAL_W-1:0] result_value,
	output logic                             is_missing
);

	logic           push;
	logic           push_ready;
	wnr_pkg::cell_t push_data;
	logic           head_valid;
	logic           pop;
	wnr_pkg::cell_t head;

	wnr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.weight        (weight),
		.last_neighbor (last_neighbor),
		.push          (push),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	wnr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	wnr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.head_valid   (head_valid),
		.pop          (pop),
		.head         (head),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.is_missing   (is_missing)
	);

endmodule

// File: tb/sv/tb_weighted_neighbor_regrid.sv
// Self-checking testbench for weighted_neighbor_regrid: streams neighbor items, predicts each
// cell result from its own fixed-point accumulator, and checks every result transfer.
// Depends on wnr_pkg and the weighted_neighbor_regrid RTL only.
module tb_weighted_neighbor_regrid;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VAL_W  = wnr_pkg::VAL_W;
	localparam int WT_W   = wnr_pkg::WT_W;
	localparam int PROD_W = wnr_pkg::PROD_W;
	localparam int SUM_W  = wnr_pkg::SUM_W;
	localparam int DEN_W  = wnr_pkg::DEN_W;

	localparam int LIMIT        = 1_000_000;
	localparam int DRAIN_CYCLES = 100;   // margin for a divide plus queue slack
	localparam int HOLD_CYCLES  = 1000;
	localparam logic signed [SUM_W-1:0] NUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] NUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct {
		logic signed [VAL_W-1:0] sample;
		logic signed [WT_W-1:0]  weight;
		logic                    last;
	} nbr_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             missing;
	} cell_res_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [VAL_W-1:0]        cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic signed [WT_W-1:0]  weight = '0;
	logic                    last_neighbor = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] result_value;
	logic                    is_missing;

	// cell accumulator copy
	logic signed [SUM_W-1:0] num_acc = '0;
	logic [DEN_W-1:0]        den_acc = '0;
	logic [VAL_W-1:0]        match_sample = '0;
	logic                    match_seen = 1'b0;
	logic [VAL_W-1:0]        fill_val = '0;

	nbr_t      neighbor_q[$];
	cell_res_t cell_results_q[$];
	int        items_queued = 0;
	int        items_taken = 0;
	int        errors = 0;
	int        cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      hold_kick = 1'b0;
	int        hold_left = 0;

	weighted_neighbor_regrid DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.weight        (weight),
		.last_neighbor (last_neighbor),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_value  (result_value),
		.is_missing    (is_missing)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// round to nearest, ties away from zero, then clamp to 32 signed bits
	function automatic logic [VAL_W-1:0] round_div(logic signed [SUM_W-1:0] num,
			logic [DEN_W-1:0] den);
		logic             neg;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] q;
		logic [SUM_W-1:0] r;
		neg = num[SUM_W-1];
		mag = neg ? -num : num;
		q = mag / den;
		r = mag % den;
		if ((r << 1) >= {{(SUM_W-DEN_W){1'b0}}, den})
			q = q + 1;
		if (!neg)
			return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[VAL_W-1:0];
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		q = -q;
		return q[VAL_W-1:0];
	endfunction

	task automatic fold_neighbor(input logic signed [VAL_W-1:0] smp,
			input logic signed [WT_W-1:0] wt, input logic lst);
		logic signed [PROD_W-1:0] prod;
		logic signed [SUM_W:0]    wide;
		logic [DEN_W:0]           den_wide;
		cell_res_t                res;
		if (wt < 0) begin
			match_sample = smp;
			match_seen = 1'b1;
		end else begin
			prod = smp * wt;
			wide = num_acc + prod;
			if (wide[SUM_W] != wide[SUM_W-1])
				num_acc = wide[SUM_W] ? NUM_MIN : NUM_MAX;
			else
				num_acc = wide[SUM_W-1:0];
			den_wide = {1'b0, den_acc} + {{(DEN_W-WT_W+1){1'b0}}, wt};
			den_acc = den_wide[DEN_W] ? '1 : den_wide[DEN_W-1:0];
		end
		if (lst) begin
			res.missing = 1'b0;
			if (den_acc == 0) begin
				res.value = fill_val;
				res.missing = 1'b1;
			end else if (match_seen) begin
				res.value = match_sample;
			end else begin
				res.value = round_div(num_acc, den_acc);
			end
			cell_results_q.push_back(res);
			num_acc = '0;
			den_acc = '0;
			match_sample = '0;
			match_seen = 1'b0;
		end
	endtask

	function automatic logic [VAL_W-1:0] pick_sample();
		int k;
		k = $urandom_range(99);
		if (k < 3)
			return 32'h7FFF_FFFF;
		if (k < 6)
			return 32'h8000_0000;
		if (k < 8)
			return '0;
		if (k < 10)
			return '1;
		if (k < 40)
			return 32'($urandom_range(2**20)) - 32'(2**19);
		return $urandom;
	endfunction

	function automatic logic [WT_W-1:0] pick_weight();
		int k;
		k = $urandom_range(99);
		if (k < 12)
			return {1'b1, 23'($urandom)};   // exact match
		if (k < 22)
			return '0;
		if (k < 35)
			return WT_W'($urandom_range(255, 1));
		return WT_W'($urandom_range(8388607, 1));
	endfunction

	task automatic push_nbr(input logic [VAL_W-1:0] smp, input logic [WT_W-1:0] wt,
			input logic lst);
		nbr_t n;
		n.sample = smp;
		n.weight = wt;
		n.last = lst;
		neighbor_q.push_back(n);
		items_queued++;
	endtask

	task automatic fill_random(input int target);
		int count;
		int len;
		count = 0;
		while (count < target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
			for (int i = 0; i < len; i++)
				push_nbr(pick_sample(), pick_weight(), i == len - 1);
			count += len;
		end
	endtask

	task automatic wait_drain();
		while (items_taken != items_queued || cell_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_missing(input logic [VAL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fill_val = v;
	endtask

	// driver: new item only once the current one has transferred
	always @(posedge clk or negedge arst_n) begin
		nbr_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample_value <= '0;
			weight <= '0;
			last_neighbor <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				fold_neighbor(sample_value, weight, last_neighbor);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (neighbor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = neighbor_q.pop_front();
					sample_value <= nxt.sample;
					weight <= nxt.weight;
					last_neighbor <= nxt.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		cell_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (cell_results_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %h missing %b",
						$time, result_value, is_missing);
					errors++;
				end else begin
					want = cell_results_q.pop_front();
					if (result_value !== want.value) begin
						$display("%0t: result_value expected %h, got %h",
							$time, want.value, result_value);
						errors++;
					end
					if (is_missing !== want.missing) begin
						$display("%0t: is_missing expected %b, got %b",
							$time, want.missing, is_missing);
						errors++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, cell_results_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cells, missing value still at its reset value
		push_nbr(32'h1234_5678, 24'h00_0000, 1'b1);          // zero weight only
		push_nbr(32'h7FFF_FFFF, 24'h80_0000, 1'b1);          // exact match, no weight
		push_nbr(32'h0001_0000, 24'h01_0000, 1'b0);          // later exact match wins
		push_nbr(32'hABCD_0000, 24'hFF_FFFF, 1'b0);
		push_nbr(32'h7FFF_FFFF, 24'hFF_FFFB, 1'b0);
		push_nbr(32'h0002_0000, 24'h00_0000, 1'b1);
		push_nbr(32'h0000_0001, 24'h00_0001, 1'b0);          // tie rounds up
		push_nbr(32'h0000_0002, 24'h00_0001, 1'b1);
		push_nbr(32'hFFFF_FFFF, 24'h00_0001, 1'b0);          // tie rounds away from zero
		push_nbr(32'hFFFF_FFFE, 24'h00_0001, 1'b1);
		push_nbr(32'h7FFF_FFFF, 24'h7F_FFFF, 1'b0);
		push_nbr(32'h8000_0000, 24'h7F_FFFF, 1'b1);
		push_nbr(32'h8000_0000, 24'h7F_FFFF, 1'b1);
		push_nbr(32'h7FFF_FFFF, 24'h00_0001, 1'b1);
		push_nbr(32'h0005_0000, 24'h00_0003, 1'b0);
		push_nbr(32'h0007_0000, 24'h00_0000, 1'b0);
		push_nbr(32'hFFFD_0000, 24'h01_0000, 1'b1);
		push_nbr(32'h5555_AAAA, 24'h80_0000, 1'b0);
		push_nbr(32'h0000_0000, 24'h7F_FFFF, 1'b1);

		for (int p = 0; p < 4; p++) begin
			wait_drain();
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_missing(32'h7FFF_FFFF);
				end
				1: begin
					send_idle_pct = 56;
					recv_stall_pct = 0;
					write_missing($urandom);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 56;
					write_missing('0);
				end
				default: begin
					send_idle_pct = 25;
					recv_stall_pct = 25;
					write_missing($urandom);
				end
			endcase
			fill_random(130);
		end

		// receiver holds off while short dividing cells keep coming
		wait_drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_missing($urandom);
		hold_kick <= 1'b1;
		@(posedge clk);
		hold_kick <= 1'b0;
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 0)
				push_nbr(pick_sample(), WT_W'($urandom_range(8388607, 1)), 1'b0);
			push_nbr(pick_sample(), WT_W'($urandom_range(8388607, 1)), 1'b1);
		end

		// long cells: numerator and denominator saturate, quotient clamps
		wait_drain();
		send_idle_pct = 25;
		recv_stall_pct = 25;
		write_missing(32'h8000_0000);
		for (int i = 0; i < 520; i++)
			push_nbr(32'h7FFF_FFFF, 24'h7F_FFFF, i == 519);
		for (int i = 0; i < 520; i++)
			push_nbr(32'h8000_0000, 24'h7F_FFFF, i == 519);

		wait_drain();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
